// File: hdl/rv32d_pkg.sv
// Package for the RV32 instruction decoder: opcodes, format classes,
// the decoded result record and the opcode classifier.
// Depends on nothing; the decoder modules and the testbench import it.
package rv32d_pkg;

  // Base opcodes of the 32-bit instruction set.
  localparam logic [6:0] OP_LUI      = 7'h37;
  localparam logic [6:0] OP_AUIPC    = 7'h17;
  localparam logic [6:0] OP_JAL      = 7'h6f;
  localparam logic [6:0] OP_JALR     = 7'h67;
  localparam logic [6:0] OP_LOAD     = 7'h03;
  localparam logic [6:0] OP_LOAD_FP  = 7'h07;
  localparam logic [6:0] OP_OP_IMM   = 7'h13;
  localparam logic [6:0] OP_BRANCH   = 7'h63;
  localparam logic [6:0] OP_STORE    = 7'h23;
  localparam logic [6:0] OP_STORE_FP = 7'h27;
  localparam logic [6:0] OP_OP       = 7'h33;
  localparam logic [6:0] OP_OP_FP    = 7'h53;
  localparam logic [6:0] OP_AMO      = 7'h2f;
  localparam logic [6:0] OP_SYSTEM   = 7'h73;

  // Encoding of the full-size breakpoint instruction.
  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

  // Low two bits that mark a full 32-bit instruction.
  localparam logic [1:0] QUAD_FULL = 2'b11;

  // Format classes reported with each result.
  typedef enum logic [2:0] {
    CLS_UNKNOWN = 3'd0,
    CLS_R       = 3'd1,
    CLS_I       = 3'd2,
    CLS_S       = 3'd3,
    CLS_B       = 3'd4,
    CLS_U       = 3'd5,
    CLS_J       = 3'd6,
    CLS_SYS     = 3'd7
  } fmt_class_e;

  // One decoded instruction.
  typedef struct packed {
    logic              valid_res;
    logic              is_compressed;
    logic [31:0]       raw_word;
    logic [6:0]        major_opcode;
    logic [4:0]        dest_reg;
    logic [2:0]        func3;
    logic [4:0]        src1_reg;
    logic [4:0]        src2_reg;
    logic [6:0]        func7;
    logic signed [31:0] immediate;
    fmt_class_e        format_class;
  } rv32d_dec_t;

  // Maps a base opcode to its format class.
  function automatic fmt_class_e classify(input logic [6:0] op);
    fmt_class_e cls;
    case (op)
      OP_LUI, OP_AUIPC:                          cls = CLS_U;
      OP_JAL:                                    cls = CLS_J;
      OP_JALR, OP_LOAD, OP_LOAD_FP, OP_OP_IMM:   cls = CLS_I;
      OP_BRANCH:                                 cls = CLS_B;
      OP_STORE, OP_STORE_FP:                     cls = CLS_S;
      OP_OP, OP_OP_FP, OP_AMO:                   cls = CLS_R;
      OP_SYSTEM:                                 cls = CLS_SYS;
      default:                                   cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

endpackage

// File: hdl/rv32d_in_if.sv
// Input channel of the RV32 instruction decoder: one fetched word per item.
// Standalone interface; no package needed.
interface rv32d_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

// File: hdl/rv32d_out_if.sv
// Output channel of the RV32 instruction decoder: one decoded result per item.
// Standalone interface; no package needed.
interface rv32d_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic               is_compressed;
  logic [31:0]        raw_word;
  logic [6:0]         major_opcode;
  logic [4:0]         dest_reg;
  logic [2:0]         func3;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic [6:0]         func7;
  logic signed [31:0] immediate;
  logic [2:0]         format_class;

  modport source (
    output valid, output valid_res, output is_compressed, output raw_word,
    output major_opcode, output dest_reg, output func3, output src1_reg,
    output src2_reg, output func7, output immediate, output format_class,
    input ready
  );
  modport sink (
    input valid, input valid_res, input is_compressed, input raw_word,
    input major_opcode, input dest_reg, input func3, input src1_reg,
    input src2_reg, input func7, input immediate, input format_class,
    output ready
  );
endinterface

// File: hdl/rv32_instruction_decoder_top.sv
// Top level of the RV32 instruction decoder with compressed expansion.
// Depends on rv32d_pkg, rv32d_in_if, rv32d_out_if, rv32d_split, rv32d_expand.
//
//   Port    Dir  Payload                                  Moves
//   in_i    in   instruction_word                         one fetched word
//   out_o   out  valid_res .. format_class (11 fields)    one decoded result
//
// Each item passes through an input register, then the decode logic, then
// the result register. One item is accepted every cycle while the output
// does not stall; the result register and the input register form two
// stages whose ready depends on the stage's own valid flag and the next stage.
// A stall at the output holds both stages; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties both stages; there is no other state.
module rv32_instruction_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  rv32d_in_if.sink    in_i,
  rv32d_out_if.source out_o
);
  import rv32d_pkg::*;

  logic        s1_valid_q;
  logic        s1_valid_d;
  logic [31:0] s1_word_q;
  logic [31:0] s1_word_d;
  logic        out_valid_q;
  logic        out_valid_d;
  rv32d_dec_t  res_q;
  rv32d_dec_t  res_d;
  rv32d_dec_t  dec_full;
  rv32d_dec_t  dec_half;
  logic        s2_ready;
  logic        in_ready;

  // Handshake: each stage moves when the stage after it can take an item.
  assign s2_ready = !out_valid_q || out_o.ready;
  assign in_ready = !s1_valid_q || s2_ready;
  assign in_i.ready = in_ready;

  // Decode paths for both instruction sizes.
  rv32d_split u_split (
    .word_i (s1_word_q),
    .dec_o  (dec_full)
  );

  rv32d_expand u_expand (
    .half_i (s1_word_q[15:0]),
    .dec_o  (dec_half)
  );

  // Next values of both stages.
  always_comb begin
    s1_valid_d  = in_ready ? in_i.valid : s1_valid_q;
    s1_word_d   = (in_i.valid && in_ready) ? in_i.instruction_word : s1_word_q;
    out_valid_d = s2_ready ? s1_valid_q : out_valid_q;
    if (s1_valid_q && s2_ready) begin
      res_d = (s1_word_q[1:0] == QUAD_FULL) ? dec_full : dec_half;
    end else begin
      res_d = res_q;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    s1_word_q <= s1_word_d;
    res_q     <= res_d;
  end

  // Result port.
  assign out_o.valid         = out_valid_q;
  assign out_o.valid_res     = res_q.valid_res;
  assign out_o.is_compressed = res_q.is_compressed;
  assign out_o.raw_word      = res_q.raw_word;
  assign out_o.major_opcode  = res_q.major_opcode;
  assign out_o.dest_reg      = res_q.dest_reg;
  assign out_o.func3         = res_q.func3;
  assign out_o.src1_reg      = res_q.src1_reg;
  assign out_o.src2_reg      = res_q.src2_reg;
  assign out_o.func7         = res_q.func7;
  assign out_o.immediate     = res_q.immediate;
  assign out_o.format_class  = res_q.format_class;

  // A rejected encoding carries an all-zero record.
  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.valid_res |-> res_q == '0)
    else $error("illegal encoding result has nonzero fields");

  // Only a decoded instruction is marked compressed.
  a_comp_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.is_compressed |-> res_q.valid_res)
    else $error("compressed flag set on an illegal encoding");

  // A full-size result keeps the marker bits of its word.
  a_full_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.valid_res && !res_q.is_compressed
      |-> res_q.raw_word[1:0] == QUAD_FULL)
    else $error("full-size result without full-size marker bits");

  // Upper-immediate results have a clear low twelve bits.
  a_upper_imm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.format_class == CLS_U |-> res_q.immediate[11:0] == '0)
    else $error("upper immediate has low bits set");

  // A held input stage keeps its item until the result stage frees up.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_word_q))
    else $error("input stage lost its item during a stall");

endmodule

// File: hdl/rv32d_split.sv
// Field split of a full 32-bit instruction: fields, class and immediate.
// Depends on rv32d_pkg.
module rv32d_split (
  input  logic [31:0]            word_i,
  output rv32d_pkg::rv32d_dec_t  dec_o
);
  import rv32d_pkg::*;

  fmt_class_e cls;

  assign cls = classify(word_i[6:0]);

  // Plain field slices plus the immediate of the format the class names.
  always_comb begin
    dec_o               = '0;
    dec_o.valid_res     = 1'b1;
    dec_o.is_compressed = 1'b0;
    dec_o.raw_word      = word_i;
    dec_o.major_opcode  = word_i[6:0];
    dec_o.dest_reg      = word_i[11:7];
    dec_o.func3         = word_i[14:12];
    dec_o.src1_reg      = word_i[19:15];
    dec_o.src2_reg      = word_i[24:20];
    dec_o.func7         = word_i[31:25];
    dec_o.format_class  = cls;
    case (cls)
      CLS_S: begin
        dec_o.immediate = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
      end
      CLS_B: begin
        dec_o.immediate = {{19{word_i[31]}}, word_i[31], word_i[7], word_i[30:25],
                           word_i[11:8], 1'b0};
      end
      CLS_U: begin
        dec_o.immediate = {word_i[31:12], 12'b0};
      end
      CLS_J: begin
        dec_o.immediate = {{11{word_i[31]}}, word_i[31], word_i[19:12], word_i[20],
                           word_i[30:21], 1'b0};
      end
      default: begin
        dec_o.immediate = {{20{word_i[31]}}, word_i[31:20]};
      end
    endcase
  end

endmodule

// File: hdl/rv32d_expand.sv
// Expansion of a 16-bit compressed instruction into the fields of its
// 32-bit equivalent, with detection of reserved encodings.
// Depends on rv32d_pkg.
module rv32d_expand (
  input  logic [15:0]            half_i,
  output rv32d_pkg::rv32d_dec_t  dec_o
);
  import rv32d_pkg::*;

  // Quadrants.
  localparam logic [1:0] Q0 = 2'b00;
  localparam logic [1:0] Q1 = 2'b01;

  // Quadrant 0 function codes.
  localparam logic [2:0] C0_ADDI4SPN = 3'd0;
  localparam logic [2:0] C0_FLD      = 3'd1;
  localparam logic [2:0] C0_LW       = 3'd2;
  localparam logic [2:0] C0_FLW      = 3'd3;
  localparam logic [2:0] C0_FSD      = 3'd5;
  localparam logic [2:0] C0_SW       = 3'd6;
  localparam logic [2:0] C0_FSW      = 3'd7;

  // Quadrant 1 function codes.
  localparam logic [2:0] C1_ADDI     = 3'd0;
  localparam logic [2:0] C1_JAL      = 3'd1;
  localparam logic [2:0] C1_LI       = 3'd2;
  localparam logic [2:0] C1_LUI      = 3'd3;
  localparam logic [2:0] C1_MISC_ALU = 3'd4;
  localparam logic [2:0] C1_J        = 3'd5;

  // Quadrant 2 function codes.
  localparam logic [2:0] C2_SLLI     = 3'd0;
  localparam logic [2:0] C2_FLDSP    = 3'd1;
  localparam logic [2:0] C2_LWSP     = 3'd2;
  localparam logic [2:0] C2_FLWSP    = 3'd3;
  localparam logic [2:0] C2_JR_ADD   = 3'd4;
  localparam logic [2:0] C2_FSDSP    = 3'd5;
  localparam logic [2:0] C2_SWSP     = 3'd6;

  // Sub-codes of the quadrant 1 ALU group.
  localparam logic [1:0] ALU_SRLI = 2'd0;
  localparam logic [1:0] ALU_SRAI = 2'd1;
  localparam logic [1:0] ALU_ANDI = 2'd2;

  // Function fields of the 32-bit forms.
  localparam logic [2:0] F3_ADD    = 3'd0;
  localparam logic [2:0] F3_SLL    = 3'd1;
  localparam logic [2:0] F3_WORD   = 3'd2;
  localparam logic [2:0] F3_DOUBLE = 3'd3;
  localparam logic [2:0] F3_XOR    = 3'd4;
  localparam logic [2:0] F3_SR     = 3'd5;
  localparam logic [2:0] F3_OR     = 3'd6;
  localparam logic [2:0] F3_AND    = 3'd7;
  localparam logic [6:0] F7_ALT    = 7'h20;

  // Fixed registers.
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  logic [2:0]  f3;
  logic [4:0]  rdp;
  logic [4:0]  rs1p;
  logic [4:0]  rfull;
  logic [4:0]  r2full;
  logic        b12;
  logic [1:0]  alu_sel;
  logic [1:0]  alu_op;
  logic [31:0] ci_imm;
  logic [31:0] wimm;
  logic [31:0] dimm;
  logic [31:0] jimm;
  logic [31:0] bimm;
  logic [9:0]  spn_imm;
  logic [9:0]  sp16_imm;

  // Common field extracts of the compressed encodings.
  assign f3       = half_i[15:13];
  assign rdp      = {2'b01, half_i[4:2]};
  assign rs1p     = {2'b01, half_i[9:7]};
  assign rfull    = half_i[11:7];
  assign r2full   = half_i[6:2];
  assign b12      = half_i[12];
  assign alu_sel  = half_i[11:10];
  assign alu_op   = half_i[6:5];
  assign ci_imm   = {{26{b12}}, b12, half_i[6:2]};
  assign wimm     = {25'b0, half_i[5], half_i[12:10], half_i[6], 2'b00};
  assign dimm     = {24'b0, half_i[6:5], half_i[12:10], 3'b000};
  assign jimm     = {{20{b12}}, b12, half_i[8], half_i[10:9], half_i[6], half_i[7],
                     half_i[2], half_i[11], half_i[5:3], 1'b0};
  assign bimm     = {{23{b12}}, b12, half_i[6:5], half_i[2], half_i[11:10],
                     half_i[4:3], 1'b0};
  assign spn_imm  = {half_i[10:7], half_i[12:11], half_i[5], half_i[6], 2'b00};
  assign sp16_imm = {b12, half_i[4:3], half_i[5], half_i[2], half_i[6], 4'b0000};

  // Expansion per quadrant and function code; reserved forms clear ok.
  always_comb begin
    logic ok;
    ok       = 1'b1;
    dec_o    = '0;
    dec_o.raw_word = {16'b0, half_i};
    case (half_i[1:0])
      Q0: begin
        case (f3)
          C0_ADDI4SPN: begin
            ok = (spn_imm != '0);
            dec_o.major_opcode = OP_OP_IMM;
            dec_o.dest_reg     = rdp;
            dec_o.src1_reg     = REG_SP;
            dec_o.immediate    = {22'b0, spn_imm};
          end
          C0_FLD: begin
            dec_o.major_opcode = OP_LOAD_FP;
            dec_o.dest_reg     = rdp;
            dec_o.func3        = F3_DOUBLE;
            dec_o.src1_reg     = rs1p;
            dec_o.immediate    = dimm;
          end
          C0_LW, C0_FLW: begin
            dec_o.major_opcode = (f3 == C0_LW) ? OP_LOAD : OP_LOAD_FP;
            dec_o.dest_reg     = rdp;
            dec_o.func3        = F3_WORD;
            dec_o.src1_reg     = rs1p;
            dec_o.immediate    = wimm;
          end
          C0_FSD: begin
            dec_o.major_opcode = OP_STORE_FP;
            dec_o.func3        = F3_DOUBLE;
            dec_o.src1_reg     = rs1p;
            dec_o.src2_reg     = rdp;
            dec_o.immediate    = dimm;
          end
          C0_SW, C0_FSW: begin
            dec_o.major_opcode = (f3 == C0_SW) ? OP_STORE : OP_STORE_FP;
            dec_o.func3        = F3_WORD;
            dec_o.src1_reg     = rs1p;
            dec_o.src2_reg     = rdp;
            dec_o.immediate    = wimm;
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      Q1: begin
        case (f3)
          C1_ADDI: begin
            dec_o.major_opcode = OP_OP_IMM;
            dec_o.dest_reg     = rfull;
            dec_o.src1_reg     = rfull;
            dec_o.immediate    = ci_imm;
          end
          C1_JAL: begin
            dec_o.major_opcode = OP_JAL;
            dec_o.dest_reg     = REG_RA;
            dec_o.immediate    = jimm;
          end
          C1_LI: begin
            dec_o.major_opcode = OP_OP_IMM;
            dec_o.dest_reg     = rfull;
            dec_o.immediate    = ci_imm;
          end
          C1_LUI: begin
            if (rfull == REG_SP) begin
              // Stack pointer adjust in steps of sixteen bytes.
              ok = (sp16_imm != '0);
              dec_o.major_opcode = OP_OP_IMM;
              dec_o.dest_reg     = REG_SP;
              dec_o.src1_reg     = REG_SP;
              dec_o.immediate    = {{22{b12}}, sp16_imm};
            end else begin
              ok = (rfull != REG_ZERO) && ({b12, half_i[6:2]} != '0);
              dec_o.major_opcode = OP_LUI;
              dec_o.dest_reg     = rfull;
              dec_o.immediate    = {ci_imm[19:0], 12'b0};
            end
          end
          C1_MISC_ALU: begin
            dec_o.dest_reg = rs1p;
            dec_o.src1_reg = rs1p;
            if (alu_sel == ALU_ANDI) begin
              dec_o.major_opcode = OP_OP_IMM;
              dec_o.func3        = F3_AND;
              dec_o.immediate    = ci_imm;
            end else if (b12) begin
              ok = 1'b0;
            end else if (alu_sel == ALU_SRLI || alu_sel == ALU_SRAI) begin
              dec_o.major_opcode = OP_OP_IMM;
              dec_o.func3        = F3_SR;
              dec_o.src2_reg     = r2full;
              dec_o.func7        = (alu_sel == ALU_SRAI) ? F7_ALT : '0;
            end else begin
              // Register-register group: sub, xor, or, and.
              dec_o.major_opcode = OP_OP;
              dec_o.src2_reg     = rdp;
              case (alu_op)
                2'd0:    dec_o.func3 = F3_ADD;
                2'd1:    dec_o.func3 = F3_XOR;
                2'd2:    dec_o.func3 = F3_OR;
                default: dec_o.func3 = F3_AND;
              endcase
              dec_o.func7 = (alu_op == 2'd0) ? F7_ALT : '0;
            end
          end
          C1_J: begin
            dec_o.major_opcode = OP_JAL;
            dec_o.immediate    = jimm;
          end
          default: begin
            // Branch if zero or not zero; the low code bit picks which.
            dec_o.major_opcode = OP_BRANCH;
            dec_o.func3        = {2'b00, f3[0]};
            dec_o.src1_reg     = rs1p;
            dec_o.immediate    = bimm;
          end
        endcase
      end
      default: begin
        case (f3)
          C2_SLLI: begin
            ok = (rfull != REG_ZERO) && !b12;
            dec_o.major_opcode = OP_OP_IMM;
            dec_o.dest_reg     = rfull;
            dec_o.func3        = F3_SLL;
            dec_o.src1_reg     = rfull;
            dec_o.src2_reg     = r2full;
          end
          C2_FLDSP: begin
            ok = (rfull != REG_ZERO);
            dec_o.major_opcode = OP_LOAD_FP;
            dec_o.dest_reg     = rfull;
            dec_o.func3        = F3_DOUBLE;
            dec_o.src1_reg     = REG_SP;
            dec_o.immediate    = {23'b0, half_i[4:2], b12, half_i[6:5], 3'b000};
          end
          C2_LWSP, C2_FLWSP: begin
            ok = (rfull != REG_ZERO);
            dec_o.major_opcode = (f3 == C2_LWSP) ? OP_LOAD : OP_LOAD_FP;
            dec_o.dest_reg     = rfull;
            dec_o.func3        = F3_WORD;
            dec_o.src1_reg     = REG_SP;
            dec_o.immediate    = {24'b0, half_i[3:2], b12, half_i[6:4], 2'b00};
          end
          C2_JR_ADD: begin
            if (b12 && rfull == REG_ZERO && r2full == REG_ZERO) begin
              // Breakpoint expands to the fixed system word.
              dec_o.major_opcode = OP_SYSTEM;
              dec_o.raw_word     = EBREAK_WORD;
            end else if (rfull == REG_ZERO) begin
              ok = 1'b0;
            end else if (r2full == REG_ZERO) begin
              dec_o.major_opcode = OP_JALR;
              dec_o.dest_reg     = {4'b0000, b12};
              dec_o.src1_reg     = rfull;
            end else begin
              dec_o.major_opcode = OP_OP;
              dec_o.dest_reg     = rfull;
              dec_o.src1_reg     = b12 ? rfull : REG_ZERO;
              dec_o.src2_reg     = r2full;
            end
          end
          C2_FSDSP: begin
            dec_o.major_opcode = OP_STORE_FP;
            dec_o.func3        = F3_DOUBLE;
            dec_o.src1_reg     = REG_SP;
            dec_o.src2_reg     = r2full;
            dec_o.immediate    = {23'b0, half_i[9:7], half_i[12:10], 3'b000};
          end
          default: begin
            dec_o.major_opcode = (f3 == C2_SWSP) ? OP_STORE : OP_STORE_FP;
            dec_o.func3        = F3_WORD;
            dec_o.src1_reg     = REG_SP;
            dec_o.src2_reg     = r2full;
            dec_o.immediate    = {24'b0, half_i[8:7], half_i[12:9], 2'b00};
          end
        endcase
      end
    endcase
    // An illegal form reports nothing but the cleared record.
    if (ok) begin
      dec_o.valid_res     = 1'b1;
      dec_o.is_compressed = 1'b1;
      dec_o.format_class  = classify(dec_o.major_opcode);
    end else begin
      dec_o = '0;
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the RV32 instruction decoder with compressed expansion.
// Depends on rv32d_pkg, rv32d_in_if, rv32d_out_if and rv32_instruction_decoder_top.
// Directed words run first, then random words; an internal decoder predicts each unfixed result.
module tb_top;
  import rv32d_pkg::*;

  // Compressed instruction groups, keyed by {funct3, quadrant}.
  typedef enum logic [4:0] {
    C_ADDI4SPN = 5'b000_00, C_FLD   = 5'b001_00, C_LW      = 5'b010_00,
    C_FLW      = 5'b011_00, C_FSD   = 5'b101_00, C_SW      = 5'b110_00,
    C_FSW      = 5'b111_00,
    C_ADDI     = 5'b000_01, C_JAL   = 5'b001_01, C_LI      = 5'b010_01,
    C_LUI      = 5'b011_01, C_MISC  = 5'b100_01, C_J       = 5'b101_01,
    C_BEQZ     = 5'b110_01, C_BNEZ  = 5'b111_01,
    C_SLLI     = 5'b000_10, C_FLDSP = 5'b001_10, C_LWSP    = 5'b010_10,
    C_FLWSP    = 5'b011_10, C_JR_ADD = 5'b100_10, C_FSDSP  = 5'b101_10,
    C_SWSP     = 5'b110_10, C_FSWSP = 5'b111_10
  } rvc_group_e;

  // Sub-operations of the compressed arithmetic group, from bits [11:10].
  localparam logic [1:0] MISC_SRLI = 2'd0;
  localparam logic [1:0] MISC_SRAI = 2'd1;
  localparam logic [1:0] MISC_ANDI = 2'd2;

  // Register-register operations of that group, from bits [6:5].
  localparam logic [1:0] ALU_SUB = 2'd0;
  localparam logic [1:0] ALU_XOR = 2'd1;
  localparam logic [1:0] ALU_OR  = 2'd2;
  localparam logic [1:0] ALU_AND = 2'd3;

  // Function codes and fixed registers used by the expansions.
  localparam logic [2:0] F3_ADD    = 3'd0;
  localparam logic [2:0] F3_SLL    = 3'd1;
  localparam logic [2:0] F3_WORD   = 3'd2;
  localparam logic [2:0] F3_DOUBLE = 3'd3;
  localparam logic [2:0] F3_XOR    = 3'd4;
  localparam logic [2:0] F3_SHR    = 3'd5;
  localparam logic [2:0] F3_OR     = 3'd6;
  localparam logic [2:0] F3_AND    = 3'd7;
  localparam logic [2:0] F3_BEQ    = 3'd0;
  localparam logic [2:0] F3_BNE    = 3'd1;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [4:0] REG_ZERO  = 5'd0;
  localparam logic [4:0] REG_RA    = 5'd1;
  localparam logic [4:0] REG_SP    = 5'd2;

  // Run shape.
  localparam int NUM_PROBES   = 25;
  localparam int NUM_RANDOM   = 800;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 10;

  // Results that can be read straight off the encoding.
  localparam rv32d_dec_t NO_DECODE = '0;
  localparam rv32d_dec_t C_EBREAK_RESULT = '{
    valid_res: 1'b1, is_compressed: 1'b1, raw_word: EBREAK_WORD,
    major_opcode: OP_SYSTEM, dest_reg: 5'd0, func3: 3'd0, src1_reg: 5'd0,
    src2_reg: 5'd0, func7: 7'd0, immediate: 32'sd0, format_class: CLS_SYS
  };
  localparam rv32d_dec_t ALL_ONES_RESULT = '{
    valid_res: 1'b1, is_compressed: 1'b0, raw_word: 32'hFFFF_FFFF,
    major_opcode: 7'h7F, dest_reg: 5'd31, func3: 3'd7, src1_reg: 5'd31,
    src2_reg: 5'd31, func7: 7'h7F, immediate: -32'sd1, format_class: CLS_UNKNOWN
  };

  typedef struct packed {
    logic [31:0] word;
    logic        fixed_want;
    rv32d_dec_t  want;
  } probe_row_t;

  // Directed words; rows without a fixed result are checked against the predictor.
  probe_row_t probes [NUM_PROBES] = '{
    '{32'h0000_0000, 1'b1, NO_DECODE},        // wide-immediate add with zero offset
    '{32'hFFFF_0000, 1'b1, NO_DECODE},        // upper half is ignored
    '{32'h0000_8000, 1'b1, NO_DECODE},        // reserved funct3 in quadrant 0
    '{32'h0000_6101, 1'b1, NO_DECODE},        // stack adjust by zero
    '{32'h0000_6005, 1'b1, NO_DECODE},        // upper immediate into x0
    '{32'h0000_6081, 1'b1, NO_DECODE},        // upper immediate of zero
    '{32'h0000_9001, 1'b1, NO_DECODE},        // right shift with bit 12 set
    '{32'h0000_9C01, 1'b1, NO_DECODE},        // register ALU with bit 12 set
    '{32'h0000_0002, 1'b1, NO_DECODE},        // left shift into x0
    '{32'h0000_4002, 1'b1, NO_DECODE},        // stack word load into x0
    '{32'h0000_2002, 1'b1, NO_DECODE},        // stack double load into x0
    '{32'h0000_8002, 1'b1, NO_DECODE},        // jump register through x0
    '{32'h0000_9002, 1'b1, C_EBREAK_RESULT},  // compressed breakpoint
    '{32'hFFFF_FFFF, 1'b1, ALL_ONES_RESULT},  // unknown opcode, every field at its top
    '{32'h0000_0001, 1'b0, NO_DECODE},        // compressed no-op
    '{32'h0000_1FFC, 1'b0, NO_DECODE},        // widest stack-pointer offset
    '{32'h0000_9082, 1'b0, NO_DECODE},        // jump and link register
    '{32'h0000_9FFE, 1'b0, NO_DECODE},        // register add
    '{32'hFFFF_FFFD, 1'b0, NO_DECODE},        // branch if nonzero, offset of minus two
    '{32'h8000_0063, 1'b0, NO_DECODE},
    '{32'hFFFF_F0B7, 1'b0, NO_DECODE},
    '{32'h8000_006F, 1'b0, NO_DECODE},
    '{32'hFE00_0FA3, 1'b0, NO_DECODE},
    '{32'h4000_5033, 1'b0, NO_DECODE},
    '{32'h0010_0073, 1'b0, NO_DECODE}
  };

  // Opcodes used to build well-formed full-size words.
  logic [6:0] base_opcodes [14] = '{
    OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_LOAD, OP_LOAD_FP, OP_OP_IMM,
    OP_BRANCH, OP_STORE, OP_STORE_FP, OP_OP, OP_OP_FP, OP_AMO, OP_SYSTEM
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  rv32d_in_if  in_if ();
  rv32d_out_if out_if ();

  rv32_instruction_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rv32d_dec_t expected_dec_q [$];
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  int         burst_left     = 0;

  // Clock generation.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Format class of a base opcode.
  function automatic fmt_class_e opcode_format(input logic [6:0] op);
    case (op)
      OP_LUI, OP_AUIPC:                        return CLS_U;
      OP_JAL:                                  return CLS_J;
      OP_JALR, OP_LOAD, OP_LOAD_FP, OP_OP_IMM: return CLS_I;
      OP_BRANCH:                               return CLS_B;
      OP_STORE, OP_STORE_FP:                   return CLS_S;
      OP_OP, OP_OP_FP, OP_AMO:                 return CLS_R;
      OP_SYSTEM:                               return CLS_SYS;
      default:                                 return CLS_UNKNOWN;
    endcase
  endfunction

  // Field split of a full-size word, with the immediate of its class.
  function automatic rv32d_dec_t split_word(input logic [31:0] w);
    rv32d_dec_t d;
    d.valid_res     = 1'b1;
    d.is_compressed = 1'b0;
    d.raw_word      = w;
    d.major_opcode  = w[6:0];
    d.dest_reg      = w[11:7];
    d.func3         = w[14:12];
    d.src1_reg      = w[19:15];
    d.src2_reg      = w[24:20];
    d.func7         = w[31:25];
    d.format_class  = opcode_format(w[6:0]);
    case (d.format_class)
      CLS_S:   d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
      CLS_B:   d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      CLS_U:   d.immediate = {w[31:12], 12'b0};
      CLS_J:   d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      default: d.immediate = {{20{w[31]}}, w[31:20]};
    endcase
    return d;
  endfunction

  // Expansion of a compressed half into the fields of its full-size form.
  function automatic rv32d_dec_t expand_half(input logic [15:0] h);
    rv32d_dec_t  d;
    logic        legal;
    logic [4:0]  rdp, rs1p, rfull, r2full;
    logic [31:0] ci_sx, wimm, dimm, jimm, bimm;
    logic [9:0]  v10;
    d      = '0;
    legal  = 1'b1;
    rdp    = {2'b01, h[4:2]};
    rs1p   = {2'b01, h[9:7]};
    rfull  = h[11:7];
    r2full = h[6:2];
    ci_sx  = {{26{h[12]}}, h[12], h[6:2]};
    wimm   = {25'b0, h[5], h[12:10], h[6], 2'b0};
    dimm   = {24'b0, h[6:5], h[12:10], 3'b0};
    jimm   = {{20{h[12]}}, h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
    bimm   = {{23{h[12]}}, h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0};
    d.raw_word = {16'h0, h};
    case ({h[15:13], h[1:0]})
      C_ADDI4SPN: begin
        v10 = {h[10:7], h[12:11], h[5], h[6], 2'b00};
        if (v10 == '0) begin
          legal = 1'b0;
        end else begin
          d.major_opcode = OP_OP_IMM; d.dest_reg = rdp; d.src1_reg = REG_SP;
          d.immediate = {22'b0, v10};
        end
      end
      C_FLD: begin
        d.major_opcode = OP_LOAD_FP; d.dest_reg = rdp; d.func3 = F3_DOUBLE;
        d.src1_reg = rs1p; d.immediate = dimm;
      end
      C_LW, C_FLW: begin
        d.major_opcode = (h[13]) ? OP_LOAD_FP : OP_LOAD;
        d.dest_reg = rdp; d.func3 = F3_WORD; d.src1_reg = rs1p; d.immediate = wimm;
      end
      C_FSD: begin
        d.major_opcode = OP_STORE_FP; d.func3 = F3_DOUBLE; d.src1_reg = rs1p;
        d.src2_reg = rdp; d.immediate = dimm;
      end
      C_SW, C_FSW: begin
        d.major_opcode = (h[13]) ? OP_STORE_FP : OP_STORE;
        d.func3 = F3_WORD; d.src1_reg = rs1p; d.src2_reg = rdp; d.immediate = wimm;
      end
      C_ADDI: begin
        d.major_opcode = OP_OP_IMM; d.dest_reg = rfull; d.src1_reg = rfull;
        d.immediate = ci_sx;
      end
      C_JAL: begin
        d.major_opcode = OP_JAL; d.dest_reg = REG_RA; d.immediate = jimm;
      end
      C_LI: begin
        d.major_opcode = OP_OP_IMM; d.dest_reg = rfull; d.immediate = ci_sx;
      end
      C_LUI: begin
        // Destination sp turns the upper-immediate slot into a stack adjust.
        if (rfull == REG_SP) begin
          v10 = {h[12], h[4:3], h[5], h[2], h[6], 4'b0};
          if (v10 == '0) begin
            legal = 1'b0;
          end else begin
            d.major_opcode = OP_OP_IMM; d.dest_reg = REG_SP; d.src1_reg = REG_SP;
            d.immediate = {{22{v10[9]}}, v10};
          end
        end else if (rfull == REG_ZERO || {h[12], h[6:2]} == '0) begin
          legal = 1'b0;
        end else begin
          d.major_opcode = OP_LUI; d.dest_reg = rfull; d.immediate = {ci_sx[19:0], 12'b0};
        end
      end
      C_MISC: begin
        d.dest_reg = rs1p;
        d.src1_reg = rs1p;
        if (h[11:10] == MISC_ANDI) begin
          d.major_opcode = OP_OP_IMM; d.func3 = F3_AND; d.immediate = ci_sx;
        end else if (h[12]) begin
          legal = 1'b0;
        end else if (h[11:10] == MISC_SRLI || h[11:10] == MISC_SRAI) begin
          d.major_opcode = OP_OP_IMM; d.func3 = F3_SHR; d.src2_reg = r2full;
          d.func7 = (h[11:10] == MISC_SRAI) ? F7_ALT : F7_BASE;
        end else begin
          d.major_opcode = OP_OP;
          d.src2_reg = rdp;
          case (h[6:5])
            ALU_SUB: begin d.func3 = F3_ADD; d.func7 = F7_ALT; end
            ALU_XOR: d.func3 = F3_XOR;
            ALU_OR:  d.func3 = F3_OR;
            ALU_AND: d.func3 = F3_AND;
          endcase
        end
      end
      C_J: begin
        d.major_opcode = OP_JAL; d.immediate = jimm;
      end
      C_BEQZ, C_BNEZ: begin
        d.major_opcode = OP_BRANCH; d.func3 = (h[13]) ? F3_BNE : F3_BEQ;
        d.src1_reg = rs1p; d.immediate = bimm;
      end
      C_SLLI: begin
        if (rfull == REG_ZERO || h[12]) begin
          legal = 1'b0;
        end else begin
          d.major_opcode = OP_OP_IMM; d.dest_reg = rfull; d.func3 = F3_SLL;
          d.src1_reg = rfull; d.src2_reg = r2full;
        end
      end
      C_FLDSP: begin
        if (rfull == REG_ZERO) begin
          legal = 1'b0;
        end else begin
          d.major_opcode = OP_LOAD_FP; d.dest_reg = rfull; d.func3 = F3_DOUBLE;
          d.src1_reg = REG_SP; d.immediate = {23'b0, h[4:2], h[12], h[6:5], 3'b0};
        end
      end
      C_LWSP, C_FLWSP: begin
        if (rfull == REG_ZERO) begin
          legal = 1'b0;
        end else begin
          d.major_opcode = (h[13]) ? OP_LOAD_FP : OP_LOAD;
          d.dest_reg = rfull; d.func3 = F3_WORD; d.src1_reg = REG_SP;
          d.immediate = {24'b0, h[3:2], h[12], h[6:4], 2'b0};
        end
      end
      C_JR_ADD: begin
        // The all-zero register fields with bit 12 set are the breakpoint.
        if (h[12] && rfull == REG_ZERO && r2full == REG_ZERO) begin
          d.major_opcode = OP_SYSTEM; d.raw_word = EBREAK_WORD;
        end else if (rfull == REG_ZERO) begin
          legal = 1'b0;
        end else if (r2full == REG_ZERO) begin
          d.major_opcode = OP_JALR; d.dest_reg = {4'b0, h[12]}; d.src1_reg = rfull;
        end else begin
          d.major_opcode = OP_OP; d.dest_reg = rfull; d.src2_reg = r2full;
          d.src1_reg = (h[12]) ? rfull : REG_ZERO;
        end
      end
      C_FSDSP: begin
        d.major_opcode = OP_STORE_FP; d.func3 = F3_DOUBLE; d.src1_reg = REG_SP;
        d.src2_reg = r2full; d.immediate = {23'b0, h[9:7], h[12:10], 3'b0};
      end
      C_SWSP, C_FSWSP: begin
        d.major_opcode = (h[13]) ? OP_STORE_FP : OP_STORE;
        d.func3 = F3_WORD; d.src1_reg = REG_SP; d.src2_reg = r2full;
        d.immediate = {24'b0, h[8:7], h[12:9], 2'b0};
      end
      default: legal = 1'b0;
    endcase
    if (legal) begin
      d.valid_res     = 1'b1;
      d.is_compressed = 1'b1;
      d.format_class  = opcode_format(d.major_opcode);
    end else begin
      d = '0;
    end
    return d;
  endfunction

  function automatic rv32d_dec_t decode_word(input logic [31:0] w);
    if (w[1:0] == QUAD_FULL) begin
      return split_word(w);
    end
    return expand_half(w[15:0]);
  endfunction

  // Random word: half are compressed halves biased toward the register corner
  // cases, most of the rest well-formed full-size words, the rest raw noise.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        w[1:0] = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) w[11:7] = REG_ZERO;
        if ($urandom_range(0, 7) == 0) w[11:7] = REG_SP;
        if ($urandom_range(0, 3) == 0) w[6:2] = 5'd0;
        if ($urandom_range(0, 7) == 0) w[12:2] = '0;
      end
      5, 6, 7, 8: w[6:0] = base_opcodes[$urandom_range(0, 13)];
      default: ;
    endcase
    return w;
  endfunction

  // Offer one word until the decoder takes it, then record its expected result.
  task automatic send_word(input logic [31:0] w, input rv32d_dec_t want);
    bit taken;
    taken = 1'b0;
    in_if.valid            <= 1'b1;
    in_if.instruction_word <= w;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end
    expected_dec_q.push_back(want);
  endtask

  // Close the current burst with a short gap once it runs out.
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  // Stimulus: reset, directed table, random words, then drain and verdict.
  initial begin
    rv32d_dec_t want;
    logic [31:0] w;
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.instruction_word = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < NUM_PROBES; i++) begin
      want = probes[i].fixed_want ? probes[i].want : decode_word(probes[i].word);
      send_word(probes[i].word, want);
      pace_sender();
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      w = random_word();
      send_word(w, decode_word(w));
      pace_sender();
    end
    in_if.valid <= 1'b0;
    while (expected_dec_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side back-pressure, with the pattern drawn at random from four modes.
  initial begin
    int cycle;
    int mode;
    cycle        = 0;
    mode         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (cycle % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= (cycle % 4 != 0);
        default: out_if.ready <= (cycle % 12 >= 7);
      endcase
      cycle++;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(negedge clk_i) begin
    rv32d_dec_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_dec_q.size() == 0) begin
        $error("result 0x%0h arrived with no item outstanding", out_if.raw_word);
        mismatch_count++;
      end else begin
        want = expected_dec_q.pop_front();
        check_field("valid_res", 32'(want.valid_res), 32'(out_if.valid_res));
        check_field("is_compressed", 32'(want.is_compressed), 32'(out_if.is_compressed));
        check_field("raw_word", want.raw_word, out_if.raw_word);
        check_field("major_opcode", 32'(want.major_opcode), 32'(out_if.major_opcode));
        check_field("dest_reg", 32'(want.dest_reg), 32'(out_if.dest_reg));
        check_field("func3", 32'(want.func3), 32'(out_if.func3));
        check_field("src1_reg", 32'(want.src1_reg), 32'(out_if.src1_reg));
        check_field("src2_reg", 32'(want.src2_reg), 32'(out_if.src2_reg));
        check_field("func7", 32'(want.func7), 32'(out_if.func7));
        check_field("immediate", want.immediate, out_if.immediate);
        check_field("format_class", 32'(want.format_class), 32'(out_if.format_class));
      end
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  always @(negedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
